/* sv/tadf_pkg.sv */
// ----------------------------------------------------------------------------
// tadf_pkg
// shared types, constants and coefficient tables of the three-axis decimating fir
// ----------------------------------------------------------------------------
package tadf_pkg;

  localparam int NumPhases = 4;
  localparam int PhW       = 2;
  localparam int TableLen  = 101;
  localparam int MaxTaps   = 128;
  localparam int NumAxes   = 3;

  localparam logic [1:0] RegTapCount  = 2'd0;
  localparam logic [1:0] RegDecPeriod = 2'd1;
  localparam logic [1:0] RegDivisor   = 2'd2;
  localparam logic [1:0] RegTableSel  = 2'd3;

  localparam logic [7:0]  TapCountRst  = 8'd101;
  localparam logic [7:0]  DecPeriodRst = 8'd100;
  localparam logic [34:0] DivisorRst   = 35'd20000000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [34:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] tap_at(input logic sel, input logic [7:0] idx);
    logic signed [31:0] one_hz [TableLen];
    logic signed [31:0] ten_hz [TableLen];
    one_hz = '{
      32'sd8636796,32'sd8908655,32'sd9386018,32'sd10078942,32'sd10996304,32'sd12145721,
      32'sd13533470,32'sd15164425,32'sd17041992,32'sd19168068,32'sd21542992,32'sd24165523,
      32'sd27032814,32'sd30140408,32'sd33482237,32'sd37050637,32'sd40836369,32'sd44828654,
      32'sd49015219,32'sd53382353,32'sd57914969,32'sd62596683,32'sd67409896,32'sd72335890,
      32'sd77354925,32'sd82446353,32'sd87588731,32'sd92759946,32'sd97937338,32'sd103097836,
      32'sd108218093,32'sd113274624,32'sd118243946,32'sd123102718,32'sd127827887,
      32'sd132396824,32'sd136787462,32'sd140978436,32'sd144949208,32'sd148680202,
      32'sd152152917,32'sd155350049,32'sd158255595,32'sd160854954,32'sd163135021,
      32'sd165084264,32'sd166692800,32'sd167952457,32'sd168856826,32'sd169401299,
      32'sd169583099,32'sd169401299,32'sd168856826,32'sd167952457,32'sd166692800,
      32'sd165084264,32'sd163135021,32'sd160854954,32'sd158255595,32'sd155350049,
      32'sd152152917,32'sd148680202,32'sd144949208,32'sd140978436,32'sd136787462,
      32'sd132396824,32'sd127827887,32'sd123102718,32'sd118243946,32'sd113274624,
      32'sd108218093,32'sd103097836,32'sd97937338,32'sd92759946,32'sd87588731,
      32'sd82446353,32'sd77354925,32'sd72335890,32'sd67409896,32'sd62596683,32'sd57914969,
      32'sd53382353,32'sd49015219,32'sd44828654,32'sd40836369,32'sd37050637,32'sd33482237,
      32'sd30140408,32'sd27032814,32'sd24165523,32'sd21542992,32'sd19168068,32'sd17041992,
      32'sd15164425,32'sd13533470,32'sd12145721,32'sd10996304,32'sd10078942,32'sd9386018,
      32'sd8908655,32'sd8636796};
    ten_hz = '{
      32'sd0,32'sd1391726,32'sd2793204,32'sd4138558,32'sd5326427,32'sd6213670,32'sd6620972,
      32'sd6352075,32'sd5225729,32'sd3116746,32'sd0,-32'sd4010410,-32'sd8635275,
      -32'sd13425330,-32'sd17782794,-32'sd21011622,-32'sd22394538,-32'sd21290464,
      -32'sd17241826,-32'sd10078062,32'sd0,32'sd12369899,32'sd25984061,32'sd39421276,
      32'sd50995310,32'sd58915725,32'sd61488798,32'sd57339856,32'sd45633456,32'sd26265283,
      32'sd0,-32'sd31467268,-32'sd65541738,-32'sd98859168,-32'sd127512184,-32'sd147358633,
      -32'sd154387760,-32'sd145111842,-32'sd116945774,-32'sd68535640,32'sd0,32'sd86945715,
      32'sd189001136,32'sd301435992,32'sd418381074,32'sd533234228,32'sd639148398,
      32'sd729559640,32'sd798707963,32'sd842103460,32'sd856894491,32'sd842103460,
      32'sd798707963,32'sd729559640,32'sd639148398,32'sd533234228,32'sd418381074,
      32'sd301435992,32'sd189001136,32'sd86945715,32'sd0,-32'sd68535640,-32'sd116945774,
      -32'sd145111842,-32'sd154387760,-32'sd147358633,-32'sd127512184,-32'sd98859168,
      -32'sd65541738,-32'sd31467268,32'sd0,32'sd26265283,32'sd45633456,32'sd57339856,
      32'sd61488798,32'sd58915725,32'sd50995310,32'sd39421276,32'sd25984061,32'sd12369899,
      32'sd0,-32'sd10078062,-32'sd17241826,-32'sd21290464,-32'sd22394538,-32'sd21011622,
      -32'sd17782794,-32'sd13425330,-32'sd8635275,-32'sd4010410,32'sd0,32'sd3116746,
      32'sd5225729,32'sd6352075,32'sd6620972,32'sd6213670,32'sd5326427,32'sd4138558,
      32'sd2793204,32'sd1391726,32'sd0};
    if (int'(idx) >= TableLen || int'(idx) >= MaxTaps) begin
      return 32'sd0;
    end
    return sel ? ten_hz[idx[6:0]] : one_hz[idx[6:0]];
  endfunction

endpackage

/* sv/tadf_divider.sv */
// ----------------------------------------------------------------------------
// tadf_divider
// restoring divider, one quotient bit per cycle, unsigned 64 by 35 bits
// ----------------------------------------------------------------------------
module tadf_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tadf_pkg::div_req_t req,
  output tadf_pkg::div_rsp_t rsp
);
  import tadf_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [34:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [35:0] trial;
  logic [35:0] diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[34:0], quo_r[63]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[35]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* sv/three_axis_decimating_fir_top.sv */
// ----------------------------------------------------------------------------
// three_axis_decimating_fir_top
// three-axis decimating fir with a phase pool and one shared multiplier/divider
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  in_     | in  | x_sample, y_sample, z_sample
//  out_    | out | x_filtered, y_filtered, z_filtered
//  cfg_    | in  | index 0..3, data up to 35 bits
//  each active phase and axis takes a multiply, a divide and an add state, up to
//  12 products per request; a zero divisor skips the divider and adds zero
//  in_tready is low while a request is worked on or a result waits
//  reset clears sums and steps, loads default config; phase 0 starts active
module three_axis_decimating_fir_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x_sample, y_sample, z_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // x_filtered, y_filtered, z_filtered
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [34:0] cfg_wdata
);
  import tadf_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0]  tap_count_r;
  logic [7:0]  dec_period_r;
  logic [34:0] divisor_r;
  logic        tab_sel_r;

  logic [63:0] sums_r [NumPhases][NumAxes];
  logic [7:0]  step_r [NumPhases];
  logic [NumPhases-1:0] act_r;
  logic [PhW-1:0] lead_r, tail_r;
  logic [95:0] samp_r;
  logic [95:0] out_r;

  logic [PhW-1:0] ph_r, ph_nxt;
  logic [1:0]     ax_r, ax_nxt;
  logic [63:0]    prod_r;
  logic           neg_r;
  logic           div_go_r;
  logic [63:0]    term;

  div_req_t dreq;
  div_rsp_t drsp;

  tadf_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [31:0] cur_samp;
  logic signed [31:0] cur_tap;
  logic signed [63:0] mul;
  logic [63:0] mag;

  always_comb begin
    case (ax_r)
      2'd0:    cur_samp = samp_r[31:0];
      2'd1:    cur_samp = samp_r[63:32];
      default: cur_samp = samp_r[95:64];
    endcase
    cur_tap = tap_at(tab_sel_r, step_r[ph_r]);
    mul     = cur_samp * cur_tap;
    mag     = prod_r[63] ? (~prod_r + 64'd1) : prod_r;
  end

  // start pulse in the first divide cycle
  assign dreq.start    = div_go_r && (divisor_r != '0);
  assign dreq.dividend = mag;
  assign dreq.divisor  = divisor_r;

  // first active phase at or after ph
  logic [PhW-1:0] nxt_act;
  logic           nxt_found;
  always_comb begin
    nxt_act   = '0;
    nxt_found = 1'b0;
    for (int i = NumPhases - 1; i >= 0; i--) begin
      if (act_r[i] && PhW'(i) >= ph_r) begin
        nxt_act   = PhW'(i);
        nxt_found = 1'b1;
      end
    end
  end

  // finishing logic on post-accumulate state
  logic [7:0] step_inc [NumPhases];
  logic [7:0] step_f [NumPhases];
  logic [NumPhases-1:0] act_s;
  logic [NumPhases-1:0] act_f;
  logic [PhW-1:0] tail_s, lead_s, idle_ph, best_ph, idle2;
  logic idle_found, best_found, emit;
  logic [7:0] best_st;
  always_comb begin
    for (int i = 0; i < NumPhases; i++) begin
      step_inc[i] = (act_r[i] && step_r[i] != 8'd255) ? step_r[i] + 8'd1 : step_r[i];
    end
    act_s      = act_r;
    tail_s     = tail_r;
    idle_ph    = '0;
    idle_found = 1'b0;
    for (int i = NumPhases - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        idle_ph    = PhW'(i);
        idle_found = 1'b1;
      end
    end
    if (step_inc[tail_r] >= dec_period_r && idle_found) begin
      act_s[idle_ph] = 1'b1;
      tail_s         = idle_ph;
    end
    emit = step_inc[lead_r] >= tap_count_r;
    best_ph    = '0;
    best_st    = '0;
    best_found = 1'b0;
    idle2      = '0;
    for (int i = 0; i < NumPhases; i++) begin
      if (act_s[i] && PhW'(i) != lead_r && (!best_found || step_inc[i] >= best_st)) begin
        best_ph    = PhW'(i);
        best_st    = step_inc[i];
        best_found = 1'b1;
      end
    end
    for (int i = NumPhases - 1; i >= 0; i--) begin
      if (!act_s[i] || PhW'(i) == lead_r) idle2 = PhW'(i);
    end
    lead_s = best_found ? best_ph : idle2;
    act_f  = act_s;
    for (int i = 0; i < NumPhases; i++) step_f[i] = step_inc[i];
    if (emit) begin
      act_f[lead_r]  = 1'b0;
      step_f[lead_r] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    ax_nxt    = ax_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOAD;
          ph_nxt    = '0;
        end
      end
      ST_LOAD: begin
        ax_nxt = 2'd0;
        if (nxt_found) begin
          ph_nxt    = nxt_act;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (divisor_r == '0 || drsp.done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (ax_r == 2'd2) begin
          if (ph_r == PhW'(NumPhases - 1)) begin
            state_nxt = ST_FINISH;
          end else begin
            ph_nxt    = ph_r + PhW'(1);
            state_nxt = ST_LOAD;
          end
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FINISH: state_nxt = emit ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    term = '0;
    if (divisor_r != '0) begin
      term = neg_r ? (~drsp.quotient + 64'd1) : drsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tap_count_r  <= TapCountRst;
      dec_period_r <= DecPeriodRst;
      divisor_r    <= DivisorRst;
      tab_sel_r    <= 1'b0;
      act_r        <= NumPhases'(1);
      lead_r       <= '0;
      tail_r       <= '0;
      ph_r         <= '0;
      ax_r         <= '0;
      div_go_r     <= 1'b0;
      for (int i = 0; i < NumPhases; i++) begin
        step_r[i] <= '0;
        for (int a = 0; a < NumAxes; a++) sums_r[i][a] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      ax_r     <= ax_nxt;
      div_go_r <= (state_r == ST_MUL);
      if (cfg_we) begin
        case (cfg_index)
          RegTapCount:  tap_count_r  <= cfg_wdata[7:0];
          RegDecPeriod: dec_period_r <= cfg_wdata[7:0];
          RegDivisor:   divisor_r    <= cfg_wdata;
          RegTableSel:  tab_sel_r    <= cfg_wdata[0];
          default:      tab_sel_r    <= tab_sel_r;
        endcase
      end
      if (state_r == ST_ACC) begin
        sums_r[ph_r][ax_r] <= sums_r[ph_r][ax_r] + term;
      end else if (state_r == ST_FINISH) begin
        for (int i = 0; i < NumPhases; i++) step_r[i] <= step_f[i];
        act_r  <= act_f;
        tail_r <= tail_s;
        if (emit) begin
          for (int a = 0; a < NumAxes; a++) sums_r[lead_r][a] <= '0;
          lead_r <= lead_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) samp_r <= in_tdata;
    if (state_r == ST_MUL) begin
      prod_r <= mul;
      neg_r  <= mul[63];
    end
    if (state_r == ST_FINISH) begin
      out_r <= {sums_r[lead_r][2][31:0], sums_r[lead_r][1][31:0], sums_r[lead_r][0][31:0]};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_r;

  a_ready_out : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_lead_act : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && act_r != '0) |-> act_r[lead_r] || step_r[lead_r] == '0)
    else $error("idle lead with nonzero step");
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule
